>>> rtl/teq_pkg.sv
`default_nettype none

package teq_pkg;

    localparam int KIND_W      = 8;
    localparam int TIME_W      = 32;
    localparam int STATUS_W    = 3;

    // Most events one process request may release.
    localparam int MAX_RESULTS = 16;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // Operation codes.
    localparam logic OP_CREATE  = 1'b0;
    localparam logic OP_PROCESS = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUE      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTHING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;

    // Highest event type with a defined meaning (do nothing, change consumption).
    localparam logic [KIND_W-1:0] KIND_LAST_KNOWN = 8'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] due;
    } t_entry;

endpackage

`default_nettype wire

>>> rtl/time_ordered_event_queue_top.sv
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+----------------------------------------------
// request   | in        | i_valid / o_ready  | i_operation, i_event_kind, i_due_time,
//           |           |                    | i_current_time
// result    | out       | o_valid / i_ready  | o_status, o_out_kind, o_out_time, o_last
//
// Events sit in a circular buffer (one write port, one registered read port), kept
// sorted by due time from r_head onward. A single time comparator serves both ops.
// Create: each queued event that must move up one slot costs a read state and a compare
//   state (S_INS_RD, S_INS_CMP); a full queue answers without a search. The one memory
//   port forces the read and the compare of each step into separate states.
// Process: each released event passes through S_POP_RD and S_POP_CMP; each result is held back one
//   step so its last flag is known before it is shown.
// Reset (i_rst_n low at a clock edge) empties the queue; memory contents are not cleared.
// A stalled result (o_valid high, i_ready low) holds the sequencer; new requests are
// taken only when the sequencer is idle, even while the last result still waits.

module time_ordered_event_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [teq_pkg::KIND_W-1:0]    i_event_kind,
    input  logic [teq_pkg::TIME_W-1:0]    i_due_time,
    input  logic [teq_pkg::TIME_W-1:0]    i_current_time,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [teq_pkg::STATUS_W-1:0]  o_status,
    output logic [teq_pkg::KIND_W-1:0]    o_out_kind,
    output logic [teq_pkg::TIME_W-1:0]    o_out_time,
    output logic                          o_last
);
    import teq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_POP_RD,
        S_POP_CMP,
        S_EMIT
    } t_state;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
        idx_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] p);
        idx_dec = (p == '0) ? LAST_IDX : p - 1'b1;
    endfunction

    function automatic logic [STATUS_W-1:0] kind_status(input logic [KIND_W-1:0] k);
        kind_status = (k <= KIND_LAST_KNOWN) ? ST_DUE : ST_UNKNOWN;
    endfunction

    // Event store
    t_entry mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    // Sequencer and queue control
    t_state                r_state,      n_state;
    logic [IDX_W-1:0]      r_head,       n_head;
    logic [CNT_W-1:0]      r_count,      n_count;
    logic [IDX_W-1:0]      r_pos,        n_pos;      // slot being read
    logic [IDX_W-1:0]      r_wslot,      n_wslot;    // free slot during insertion
    logic [CNT_W-1:0]      r_steps,      n_steps;    // entries left to compare
    logic [NRES_W-1:0]     r_nres,       n_nres;     // events released so far
    logic                  r_have,       n_have;     // a released event waits in r_pend

    // Payload holding
    logic [TIME_W-1:0]     r_key,        n_key;      // due time or present time
    logic [KIND_W-1:0]     r_kind,       n_kind;
    t_entry                r_pend,       n_pend;
    logic [STATUS_W-1:0]   r_p_status,   n_p_status;

    // Result register
    logic                  r_out_valid,  n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [KIND_W-1:0]     r_out_kind,   n_out_kind;
    logic [TIME_W-1:0]     r_out_time,   n_out_time;
    logic                  r_out_last,   n_out_last;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    t_entry                wr_data;

    logic [IDX_W:0]        tail_sum;
    logic [IDX_W:0]        tail_wrap;
    logic [IDX_W-1:0]      tail;
    logic                  le_key;
    logic                  due;
    logic                  out_free;
    logic                  accept;

    // Slot just past the latest-due event.
    assign tail_sum  = {1'b0, r_head} + (IDX_W + 1)'(r_count);
    assign tail_wrap = (tail_sum >= DEPTH_X) ? tail_sum - DEPTH_X : tail_sum;
    assign tail      = tail_wrap[IDX_W-1:0];

    // The shared comparator: stored due time against the key.
    assign le_key   = (r_rd_data.due <= r_key);
    assign due      = (r_count != '0) && (r_nres < NRES_W'(MAX_RESULTS)) && le_key;
    assign out_free = !r_out_valid || i_ready;
    assign accept   = i_valid && (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_pos        = r_pos;
        n_wslot      = r_wslot;
        n_steps      = r_steps;
        n_nres       = r_nres;
        n_have       = r_have;
        n_key        = r_key;
        n_kind       = r_kind;
        n_pend       = r_pend;
        n_p_status   = r_p_status;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_kind   = r_out_kind;
        n_out_time   = r_out_time;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_addr      = r_wslot;
        wr_data      = '{kind: r_kind, due: r_key};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_CREATE) begin
                        n_key  = i_due_time;
                        n_kind = i_event_kind;
                        if (r_count == FULL_CNT) begin
                            n_p_status = ST_FULL;
                            n_state    = S_EMIT;
                        end else begin
                            n_wslot = tail;
                            n_steps = r_count;
                            if (r_count == '0) begin
                                n_state = S_INS_PUT;
                            end else begin
                                n_pos   = idx_dec(tail);
                                n_state = S_INS_RD;
                            end
                        end
                    end else begin
                        n_key  = i_current_time;
                        n_pos  = r_head;
                        n_nres = '0;
                        n_have = 1'b0;
                        if (r_count == '0) begin
                            n_p_status = ST_NOTHING;
                            n_state    = S_EMIT;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end
                end
            end

            S_INS_RD: begin
                n_state = S_INS_CMP;
            end

            S_INS_CMP: begin
                wr_en = 1'b1;
                if (!le_key) begin
                    // Later event: move it up one slot and keep searching.
                    wr_data = r_rd_data;
                    n_wslot = r_pos;
                    n_steps = r_steps - 1'b1;
                    if (r_steps == CNT_W'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_pos   = idx_dec(r_pos);
                        n_state = S_INS_RD;
                    end
                end else begin
                    // Equal or earlier: the new event lands just behind it.
                    n_count    = r_count + 1'b1;
                    n_p_status = ST_ACCEPTED;
                    n_state    = S_EMIT;
                end
            end

            S_INS_PUT: begin
                wr_en      = 1'b1;
                n_count    = r_count + 1'b1;
                n_p_status = ST_ACCEPTED;
                n_state    = S_EMIT;
            end

            S_POP_RD: begin
                n_state = S_POP_CMP;
            end

            S_POP_CMP: begin
                if (!r_have || out_free) begin
                    if (r_have) begin
                        n_out_valid  = 1'b1;
                        n_out_status = kind_status(r_pend.kind);
                        n_out_kind   = r_pend.kind;
                        n_out_time   = r_pend.due;
                        n_out_last   = !due;
                    end
                    if (due) begin
                        // Take the head event and look at the next one.
                        n_pend  = r_rd_data;
                        n_have  = 1'b1;
                        n_head  = idx_inc(r_head);
                        n_pos   = idx_inc(r_head);
                        n_count = r_count - 1'b1;
                        n_nres  = r_nres + 1'b1;
                        n_state = S_POP_RD;
                    end else if (r_have) begin
                        n_have  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_p_status = ST_NOTHING;
                        n_state    = S_EMIT;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_p_status;
                    n_out_kind   = '0;
                    n_out_time   = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
        r_pos        <= n_pos;
        r_wslot      <= n_wslot;
        r_steps      <= n_steps;
        r_nres       <= n_nres;
        r_key        <= n_key;
        r_kind       <= n_kind;
        r_pend       <= n_pend;
        r_p_status   <= n_p_status;
        r_out_status <= n_out_status;
        r_out_kind   <= n_out_kind;
        r_out_time   <= n_out_time;
        r_out_last   <= n_out_last;
    end

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[r_pos];
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_out_kind = r_out_kind;
    assign o_out_time = r_out_time;
    assign o_last     = r_out_last;

endmodule

`default_nettype wire

>>> rtl/teq_checker.sv
`default_nettype none

module teq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          i_operation,
    input logic [teq_pkg::KIND_W-1:0]    i_event_kind,
    input logic [teq_pkg::TIME_W-1:0]    i_due_time,
    input logic [teq_pkg::TIME_W-1:0]    i_current_time,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [teq_pkg::STATUS_W-1:0]  o_status,
    input logic [teq_pkg::KIND_W-1:0]    o_out_kind,
    input logic [teq_pkg::TIME_W-1:0]    o_out_time,
    input logic                          o_last
);
    import teq_pkg::*;

    // Hold a waiting request.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_operation) && $stable(i_event_kind)
                                && $stable(i_due_time) && $stable(i_current_time))
        else $error("waiting request changed");

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_out_kind)
                                && $stable(o_out_time) && $stable(o_last))
        else $error("stalled result changed");

    // Create answers and nothing-due answers close their request.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ACCEPTED || o_status == ST_FULL
                    || o_status == ST_NOTHING) |-> o_last)
        else $error("single-result answer without last");

    // Only released events carry a type and a time.
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DUE && o_status != ST_UNKNOWN
            |-> o_out_kind == '0 && o_out_time == '0)
        else $error("non-event result carries payload");

    // Known and unknown types are flagged consistently.
    a_kind_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DUE || o_status == ST_UNKNOWN)
            |-> (o_status == ST_DUE) == (o_out_kind <= KIND_LAST_KNOWN))
        else $error("event type flag mismatch");

endmodule

bind time_ordered_event_queue_top teq_checker u_teq_checker (.*);

`default_nettype wire
